// File: src/rqi_pkg.sv
package rqi_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int NRM_W       = 16;
  localparam int FRAC        = 14;
  localparam int T_W         = 19;
  localparam int SIZE_W      = 19;
  localparam int EPS_W       = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CORNER_W    = 3 * COORD_WIDTH;
  localparam int NVEC_W      = 3 * NRM_W;

  localparam logic [T_W-1:0] DIST_MAX = {T_W{1'b1}};
  localparam logic [SIZE_W-1:0] MIN_DIST_RST = SIZE_W'(41);
  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);

  // setup arithmetic
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PD_W   = 2 * NRM_W;
  localparam int PN_W   = DIFF_W + NRM_W;
  localparam int D_W    = PD_W + 2;
  localparam int NUM_W  = PN_W + 2;
  localparam int DM_W   = D_W;
  localparam int NM_W   = NUM_W;
  localparam int REM_W  = NM_W + FRAC;

  // hit point arithmetic
  localparam int M_W    = NRM_W + T_W + 1;
  localparam int PW_W   = ((COORD_WIDTH + FRAC > M_W) ? COORD_WIDTH + FRAC : M_W) + 1;
  localparam int P_W    = PW_W - FRAC;
  localparam int REL_W  = ((P_W > COORD_WIDTH) ? P_W : COORD_WIDTH) + 1;
  localparam int UP_W   = REL_W + NRM_W;
  localparam int UV_W   = UP_W + 2;
  localparam int SAT_W  = UV_W - FRAC;

  localparam int SETUP_STAGES = 3;
  localparam int HP_STAGES    = 5;
  localparam int LATENCY      = SETUP_STAGES + T_W + HP_STAGES;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORNER = 3'd0,
    REG_PLANE  = 3'd1,
    REG_HORIZ  = 3'd2,
    REG_VERT   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5,
    REG_MIN    = 3'd6,
    REG_EPS    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CORNER_W-1:0] corner;
    logic [NVEC_W-1:0]   pn;
    logic [NVEC_W-1:0]   hn;
    logic [NVEC_W-1:0]   vn;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
    logic [SIZE_W-1:0]   min_dist;
    logic [EPS_W-1:0]    eps;
  } cfg_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] o;
    logic [2:0][NRM_W-1:0]       dir;
  } ray_t;

  typedef struct packed {
    logic            valid;
    logic            ok;
    logic            neg_d;
    logic            sat;
    logic [NM_W-1:0] nm;
    logic [DM_W-1:0] dm;
    ray_t            ray;
  } div_in_t;

  typedef struct packed {
    logic             ok;
    logic             neg_d;
    logic             sat;
    logic [REM_W-1:0] rem;
    logic [T_W-1:0]   quo;
    logic [DM_W-1:0]  dm;
    ray_t             ray;
  } div_st_t;

  typedef struct packed {
    logic           valid;
    logic           ok;
    logic           neg_d;
    logic [T_W-1:0] t;
    ray_t           ray;
  } hp_in_t;

  typedef struct packed {
    logic                   done;
    logic                   hit;
    logic [T_W-1:0]         hit_dist;
    logic [2:0][COORD_WIDTH-1:0] p;
    logic [COORD_WIDTH-1:0] u;
    logic [COORD_WIDTH-1:0] v;
    logic                   front;
  } result_t;

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed(SAT_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1));
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      return hi[COORD_WIDTH-1:0];
    end else if (x < lo) begin
      return lo[COORD_WIDTH-1:0];
    end
    return x[COORD_WIDTH-1:0];
  endfunction

endpackage

// File: src/rqi_setup.sv
module rqi_setup (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rqi_pkg::ray_t    ray_i,
  input  rqi_pkg::cfg_t    cfg_i,
  output rqi_pkg::div_in_t div_o
);

  logic signed [rqi_pkg::DIFF_W-1:0] diff [3];
  logic signed [rqi_pkg::PD_W-1:0]   pd_d [3];
  logic signed [rqi_pkg::PD_W-1:0]   pd_q [3];
  logic signed [rqi_pkg::PN_W-1:0]   pn_d [3];
  logic signed [rqi_pkg::PN_W-1:0]   pn_q [3];
  logic                              v1_q, v2_q, v3_q;
  rqi_pkg::ray_t                     ray1_q, ray2_q;
  logic signed [rqi_pkg::D_W-1:0]    d_d, d_q;
  logic signed [rqi_pkg::NUM_W-1:0]  num_d, num_q;
  logic [rqi_pkg::DM_W-1:0]          dm;
  logic [rqi_pkg::NM_W-1:0]          nm;
  rqi_pkg::div_in_t                  out_d, out_q;

  // stage 1: per-axis products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = rqi_pkg::DIFF_W'($signed(cfg_i.corner[i*rqi_pkg::COORD_WIDTH +: rqi_pkg::COORD_WIDTH]))
              - rqi_pkg::DIFF_W'($signed(ray_i.o[i]));
      pd_d[i] = rqi_pkg::PD_W'($signed(ray_i.dir[i]))
              * rqi_pkg::PD_W'($signed(cfg_i.pn[i*rqi_pkg::NRM_W +: rqi_pkg::NRM_W]));
      pn_d[i] = rqi_pkg::PN_W'(diff[i])
              * rqi_pkg::PN_W'($signed(cfg_i.pn[i*rqi_pkg::NRM_W +: rqi_pkg::NRM_W]));
    end
  end

  // stage 2: dot product sums
  always_comb begin
    d_d   = rqi_pkg::D_W'(pd_q[0]) + rqi_pkg::D_W'(pd_q[1]) + rqi_pkg::D_W'(pd_q[2]);
    num_d = rqi_pkg::NUM_W'(pn_q[0]) + rqi_pkg::NUM_W'(pn_q[1]) + rqi_pkg::NUM_W'(pn_q[2]);
  end

  // stage 3: magnitudes and early rejects
  always_comb begin
    dm = (d_q < 0) ? unsigned'(-d_q) : unsigned'(d_q);
    nm = (num_q < 0) ? unsigned'(-num_q) : unsigned'(num_q);
    out_d.valid = v2_q;
    out_d.neg_d = d_q < 0;
    out_d.ok    = (dm >= rqi_pkg::DM_W'({cfg_i.eps, {rqi_pkg::FRAC{1'b0}}}))
                && (dm != '0)
                && !((num_q != 0) && ((num_q < 0) != (d_q < 0)));
    out_d.sat   = nm >= (rqi_pkg::NM_W'(dm) << 5);
    out_d.nm    = nm;
    out_d.dm    = dm;
    out_d.ray   = ray2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pd_q   <= pd_d;
    pn_q   <= pn_d;
    ray1_q <= ray_i;
    d_q    <= d_d;
    num_q  <= num_d;
    ray2_q <= ray1_q;
    out_q  <= out_d;
  end

  always_comb begin
    div_o       = out_q;
    div_o.valid = v3_q;
  end

endmodule

// File: src/rqi_divider.sv
module rqi_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rqi_pkg::div_in_t div_i,
  output rqi_pkg::hp_in_t  hp_o
);

  rqi_pkg::div_st_t st0;
  rqi_pkg::div_st_t st_q  [rqi_pkg::T_W];
  logic             vld_q [rqi_pkg::T_W];

  always_comb begin
    st0.ok    = div_i.ok;
    st0.neg_d = div_i.neg_d;
    st0.sat   = div_i.sat;
    st0.rem   = {div_i.nm, {rqi_pkg::FRAC{1'b0}}};
    st0.quo   = '0;
    st0.dm    = div_i.dm;
    st0.ray   = div_i.ray;
  end

  // one quotient bit per stage, MSB first
  for (genvar j = 0; j < rqi_pkg::T_W; j++) begin : g_stage
    localparam int K = rqi_pkg::T_W - 1 - j;
    rqi_pkg::div_st_t       src, nxt;
    logic                   src_v;
    logic [rqi_pkg::REM_W-1:0] sub;
    logic                   ge;

    if (j == 0) begin : g_first
      assign src   = st0;
      assign src_v = div_i.valid;
    end else begin : g_rest
      assign src   = st_q[j-1];
      assign src_v = vld_q[j-1];
    end

    always_comb begin
      sub = rqi_pkg::REM_W'(src.dm) << K;
      ge  = src.rem >= sub;
      nxt = src;
      if (ge) begin
        nxt.rem = src.rem - sub;
      end
      nxt.quo[K] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[j] <= nxt;
    end
  end

  always_comb begin
    hp_o.valid = vld_q[rqi_pkg::T_W-1];
    hp_o.ok    = st_q[rqi_pkg::T_W-1].ok;
    hp_o.neg_d = st_q[rqi_pkg::T_W-1].neg_d;
    hp_o.t     = st_q[rqi_pkg::T_W-1].sat ? rqi_pkg::DIST_MAX : st_q[rqi_pkg::T_W-1].quo;
    hp_o.ray   = st_q[rqi_pkg::T_W-1].ray;
  end

endmodule

// File: src/rqi_hitpoint.sv
module rqi_hitpoint (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rqi_pkg::hp_in_t  hp_i,
  input  rqi_pkg::cfg_t    cfg_i,
  output rqi_pkg::result_t res_o
);

  logic                              va_q, vb_q, vc_q, vd_q, ve_q;
  logic                              oka_q, okb_q, okc_q, okd_q;
  logic                              nga_q, ngb_q, ngc_q, ngd_q;
  logic [rqi_pkg::T_W-1:0]           ta_q, tb_q, tc_q, td_q;
  logic signed [rqi_pkg::M_W-1:0]    ma_d [3];
  logic signed [rqi_pkg::M_W-1:0]    ma_q [3];
  rqi_pkg::ray_t                     raya_q;
  logic signed [rqi_pkg::PW_W-1:0]   pw [3];
  logic signed [rqi_pkg::P_W-1:0]    p_d [3];
  logic signed [rqi_pkg::P_W-1:0]    pb_q [3];
  logic signed [rqi_pkg::P_W-1:0]    pc_q [3];
  logic signed [rqi_pkg::P_W-1:0]    pd_q [3];
  logic signed [rqi_pkg::REL_W-1:0]  rel_d [3];
  logic signed [rqi_pkg::REL_W-1:0]  rel_q [3];
  logic signed [rqi_pkg::UP_W-1:0]   uh_d [3];
  logic signed [rqi_pkg::UP_W-1:0]   uh_q [3];
  logic signed [rqi_pkg::UP_W-1:0]   vv_d [3];
  logic signed [rqi_pkg::UP_W-1:0]   vv_q [3];
  logic signed [rqi_pkg::UV_W-1:0]   u_d, u_q, v_d, v_q;
  logic signed [rqi_pkg::UV_W-1:0]   w_lim, h_lim;
  logic                              in_quad;
  rqi_pkg::result_t                  res_d, res_q;

  // A: minimum distance test, dir * t
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma_d[i] = rqi_pkg::M_W'($signed(hp_i.ray.dir[i])) * $signed(rqi_pkg::M_W'(hp_i.t));
    end
  end

  // B: hit point (floor shift) and offset from corner
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pw[i]    = (rqi_pkg::PW_W'($signed(raya_q.o[i])) <<< rqi_pkg::FRAC)
               + rqi_pkg::PW_W'(ma_q[i]);
      p_d[i]   = rqi_pkg::P_W'(pw[i] >>> rqi_pkg::FRAC);
      rel_d[i] = rqi_pkg::REL_W'(p_d[i])
               - rqi_pkg::REL_W'($signed(cfg_i.corner[i*rqi_pkg::COORD_WIDTH +:
                                                      rqi_pkg::COORD_WIDTH]));
    end
  end

  // C: projections onto edge normals
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uh_d[i] = rqi_pkg::UP_W'(rel_q[i])
              * rqi_pkg::UP_W'($signed(cfg_i.hn[i*rqi_pkg::NRM_W +: rqi_pkg::NRM_W]));
      vv_d[i] = rqi_pkg::UP_W'(rel_q[i])
              * rqi_pkg::UP_W'($signed(cfg_i.vn[i*rqi_pkg::NRM_W +: rqi_pkg::NRM_W]));
    end
  end

  // D: sums
  always_comb begin
    u_d = rqi_pkg::UV_W'(uh_q[0]) + rqi_pkg::UV_W'(uh_q[1]) + rqi_pkg::UV_W'(uh_q[2]);
    v_d = rqi_pkg::UV_W'(vv_q[0]) + rqi_pkg::UV_W'(vv_q[1]) + rqi_pkg::UV_W'(vv_q[2]);
  end

  // E: bounds and result; fields read zero on a miss
  always_comb begin
    w_lim   = rqi_pkg::UV_W'($signed({1'b0, cfg_i.width, {rqi_pkg::FRAC{1'b0}}}));
    h_lim   = rqi_pkg::UV_W'($signed({1'b0, cfg_i.height, {rqi_pkg::FRAC{1'b0}}}));
    in_quad = vd_q && okd_q && (u_q >= 0) && (u_q <= w_lim) && (v_q >= 0) && (v_q <= h_lim);
    res_d   = '0;
    res_d.done = vd_q;
    if (in_quad) begin
      res_d.hit      = 1'b1;
      res_d.hit_dist = td_q;
      for (int i = 0; i < 3; i++) begin
        res_d.p[i] = rqi_pkg::sat_coord(rqi_pkg::SAT_W'(pd_q[i]));
      end
      res_d.u     = rqi_pkg::sat_coord(rqi_pkg::SAT_W'(u_q >>> rqi_pkg::FRAC));
      res_d.v     = rqi_pkg::sat_coord(rqi_pkg::SAT_W'(v_q >>> rqi_pkg::FRAC));
      res_d.front = ngd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= hp_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    oka_q  <= hp_i.ok && (hp_i.t >= cfg_i.min_dist);
    nga_q  <= hp_i.neg_d;
    ta_q   <= hp_i.t;
    ma_q   <= ma_d;
    raya_q <= hp_i.ray;
    okb_q  <= oka_q;
    ngb_q  <= nga_q;
    tb_q   <= ta_q;
    pb_q   <= p_d;
    rel_q  <= rel_d;
    okc_q  <= okb_q;
    ngc_q  <= ngb_q;
    tc_q   <= tb_q;
    pc_q   <= pb_q;
    uh_q   <= uh_d;
    vv_q   <= vv_d;
    okd_q  <= okc_q;
    ngd_q  <= ngc_q;
    td_q   <= tc_q;
    pd_q   <= pc_q;
    u_q    <= u_d;
    v_q    <= v_d;
    res_q  <= res_d;
  end

  always_comb begin
    res_o      = res_q;
    res_o.done = ve_q;
  end

endmodule

// File: src/ray_quad_intersection.sv
// Ray against rectangle test, fully pipelined: one ray may be started in every
// cycle and busy_o never rises. Each started ray gives exactly one result on
// done_o after 3 setup stages for the dot products, 19 stages of the
// restoring divider, one quotient bit each, and 5 stages for hit point, u/v
// projection and bound checks. The result is shown for one cycle only and
// cannot be held off, so the receiver must take it when done_o is high. On a
// miss every field reads zero. Write the rectangle registers only while no
// ray is in flight.
module ray_quad_intersection (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [rqi_pkg::COORD_WIDTH-1:0] origin_x_i,
  input  logic signed [rqi_pkg::COORD_WIDTH-1:0] origin_y_i,
  input  logic signed [rqi_pkg::COORD_WIDTH-1:0] origin_z_i,
  input  logic signed [rqi_pkg::NRM_W-1:0]       direction_x_i,
  input  logic signed [rqi_pkg::NRM_W-1:0]       direction_y_i,
  input  logic signed [rqi_pkg::NRM_W-1:0]       direction_z_i,
  output logic                                done_o,
  output logic                                hit_o,
  output logic [rqi_pkg::T_W-1:0]             hit_distance_o,
  output logic signed [rqi_pkg::COORD_WIDTH-1:0] point_x_o,
  output logic signed [rqi_pkg::COORD_WIDTH-1:0] point_y_o,
  output logic signed [rqi_pkg::COORD_WIDTH-1:0] point_z_o,
  output logic signed [rqi_pkg::COORD_WIDTH-1:0] coord_u_o,
  output logic signed [rqi_pkg::COORD_WIDTH-1:0] coord_v_o,
  output logic                                front_entry_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rqi_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rqi_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  rqi_pkg::cfg_t    cfg_q;
  rqi_pkg::ray_t    ray;
  rqi_pkg::div_in_t div_in;
  rqi_pkg::hp_in_t  hp_in;
  rqi_pkg::result_t res;
  logic             start_ok;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign start_ok    = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{min_dist: rqi_pkg::MIN_DIST_RST, eps: rqi_pkg::EPS_RST, default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (rqi_pkg::reg_idx_e'(cfg_index_i))
        rqi_pkg::REG_CORNER: cfg_q.corner   <= rqi_pkg::CORNER_W'(cfg_data_i);
        rqi_pkg::REG_PLANE:  cfg_q.pn       <= cfg_data_i[rqi_pkg::NVEC_W-1:0];
        rqi_pkg::REG_HORIZ:  cfg_q.hn       <= cfg_data_i[rqi_pkg::NVEC_W-1:0];
        rqi_pkg::REG_VERT:   cfg_q.vn       <= cfg_data_i[rqi_pkg::NVEC_W-1:0];
        rqi_pkg::REG_WIDTH:  cfg_q.width    <= cfg_data_i[rqi_pkg::SIZE_W-1:0];
        rqi_pkg::REG_HEIGHT: cfg_q.height   <= cfg_data_i[rqi_pkg::SIZE_W-1:0];
        rqi_pkg::REG_MIN:    cfg_q.min_dist <= cfg_data_i[rqi_pkg::SIZE_W-1:0];
        rqi_pkg::REG_EPS:    cfg_q.eps      <= cfg_data_i[rqi_pkg::EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ray.o[0]   = origin_x_i;
    ray.o[1]   = origin_y_i;
    ray.o[2]   = origin_z_i;
    ray.dir[0] = direction_x_i;
    ray.dir[1] = direction_y_i;
    ray.dir[2] = direction_z_i;
  end

  rqi_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_ok),
    .ray_i   (ray),
    .cfg_i   (cfg_q),
    .div_o   (div_in)
  );

  rqi_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .div_i  (div_in),
    .hp_o   (hp_in)
  );

  rqi_hitpoint u_hitpoint (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hp_i   (hp_in),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  assign done_o         = res.done;
  assign hit_o          = res.hit;
  assign hit_distance_o = res.hit_dist;
  assign point_x_o      = res.p[0];
  assign point_y_o      = res.p[1];
  assign point_z_o      = res.p[2];
  assign coord_u_o      = res.u;
  assign coord_v_o      = res.v;
  assign front_entry_o  = res.front;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_ok |-> ##(rqi_pkg::LATENCY) done_o)
    else $error("request result missing at expected latency");

  a_hit_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_o |-> done_o && (hit_distance_o >= cfg_q.min_dist))
    else $error("hit outside strobe or below minimum distance");

  a_front_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_entry_o |-> hit_o)
    else $error("front entry flagged on a miss");
`endif

endmodule

// File: sim/ray_quad_intersection_tb.sv
`timescale 1ns / 100ps

module ray_quad_intersection_tb;

  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic                            hit;
    logic [rqi_pkg::T_W-1:0]         hit_dist;
    logic [rqi_pkg::COORD_WIDTH-1:0] px;
    logic [rqi_pkg::COORD_WIDTH-1:0] py;
    logic [rqi_pkg::COORD_WIDTH-1:0] pz;
    logic [rqi_pkg::COORD_WIDTH-1:0] u;
    logic [rqi_pkg::COORD_WIDTH-1:0] v;
    logic                            front;
  } isect_t;

  typedef struct {
    rqi_pkg::ray_t ray;
    logic          typed;
    isect_t        res;
  } ray_row_t;

  logic clk_i, rst_ni;
  logic start_i, busy_o, done_o;
  logic signed [rqi_pkg::COORD_WIDTH-1:0] origin_x_i, origin_y_i, origin_z_i;
  logic signed [rqi_pkg::NRM_W-1:0] direction_x_i, direction_y_i, direction_z_i;
  logic hit_o, front_entry_o;
  logic [rqi_pkg::T_W-1:0] hit_distance_o;
  logic signed [rqi_pkg::COORD_WIDTH-1:0] point_x_o, point_y_o, point_z_o;
  logic signed [rqi_pkg::COORD_WIDTH-1:0] coord_u_o, coord_v_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [rqi_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [rqi_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // register mirror
  logic [rqi_pkg::CORNER_W-1:0] m_corner;
  logic [rqi_pkg::NVEC_W-1:0]   m_pn, m_hn, m_vn;
  logic [rqi_pkg::SIZE_W-1:0]   m_width, m_height, m_min;
  logic [rqi_pkg::EPS_W-1:0]    m_eps;

  // quad geometry for aimed rays
  int q_axis, q_corner[3], q_w, q_h;

  isect_t expected_hits[$];
  int     fail_count;
  int     idle_pct;
  int     quiet_cycles;
  logic   progress;

  ray_quad_intersection uut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .origin_x_i, .origin_y_i, .origin_z_i,
    .direction_x_i, .direction_y_i, .direction_z_i,
    .done_o, .hit_o, .hit_distance_o,
    .point_x_o, .point_y_o, .point_z_o, .coord_u_o, .coord_v_o, .front_entry_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [rqi_pkg::COORD_WIDTH-1:0] clamp_coord(longint x);
    longint hi;
    hi = (longint'(1) <<< (rqi_pkg::COORD_WIDTH - 1)) - 1;
    if (x > hi) return rqi_pkg::COORD_WIDTH'(hi);
    if (x < -hi - 1) return rqi_pkg::COORD_WIDTH'(-hi - 1);
    return rqi_pkg::COORD_WIDTH'(x);
  endfunction

  function automatic rqi_pkg::ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    rqi_pkg::ray_t r;
    r.o[0]   = rqi_pkg::COORD_WIDTH'(ox);
    r.o[1]   = rqi_pkg::COORD_WIDTH'(oy);
    r.o[2]   = rqi_pkg::COORD_WIDTH'(oz);
    r.dir[0] = rqi_pkg::NRM_W'(dx);
    r.dir[1] = rqi_pkg::NRM_W'(dy);
    r.dir[2] = rqi_pkg::NRM_W'(dz);
    return r;
  endfunction

  function automatic isect_t predict_hit(rqi_pkg::ray_t r);
    longint o[3], dr[3], c[3], n[3], hn[3], vn[3], p[3], rel;
    longint d, num, u, v, t, dm, nm;
    isect_t res;
    res = '0;
    d = 0; num = 0; u = 0; v = 0;
    for (int i = 0; i < 3; i++) begin
      o[i]  = $signed(r.o[i]);
      dr[i] = $signed(r.dir[i]);
      c[i]  = $signed(m_corner[i*rqi_pkg::COORD_WIDTH +: rqi_pkg::COORD_WIDTH]);
      n[i]  = $signed(m_pn[i*rqi_pkg::NRM_W +: rqi_pkg::NRM_W]);
      hn[i] = $signed(m_hn[i*rqi_pkg::NRM_W +: rqi_pkg::NRM_W]);
      vn[i] = $signed(m_vn[i*rqi_pkg::NRM_W +: rqi_pkg::NRM_W]);
      d   += dr[i] * n[i];
      num += (c[i] - o[i]) * n[i];
    end
    dm = (d < 0) ? -d : d;
    if (dm < (longint'(m_eps) <<< rqi_pkg::FRAC) || dm == 0) return res;
    if (num != 0 && ((num < 0) != (d < 0))) return res;
    nm = (num < 0) ? -num : num;
    if (nm >= (dm <<< 5)) t = longint'(rqi_pkg::DIST_MAX);
    else t = (nm <<< rqi_pkg::FRAC) / dm;
    if (t < longint'(m_min)) return res;
    for (int i = 0; i < 3; i++) begin
      p[i] = (o[i] * 16384 + dr[i] * t) >>> rqi_pkg::FRAC;
      rel = p[i] - c[i];
      u += rel * hn[i];
      v += rel * vn[i];
    end
    if (u < 0 || u > (longint'(m_width) <<< rqi_pkg::FRAC)) return res;
    if (v < 0 || v > (longint'(m_height) <<< rqi_pkg::FRAC)) return res;
    res.hit      = 1'b1;
    res.hit_dist = rqi_pkg::T_W'(t);
    res.px       = clamp_coord(p[0]);
    res.py       = clamp_coord(p[1]);
    res.pz       = clamp_coord(p[2]);
    res.u        = clamp_coord(u >>> rqi_pkg::FRAC);
    res.v        = clamp_coord(v >>> rqi_pkg::FRAC);
    res.front    = (d < 0);
    return res;
  endfunction

  task automatic write_reg(rqi_pkg::reg_idx_e idx, logic [rqi_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      rqi_pkg::REG_CORNER: m_corner = data[rqi_pkg::CORNER_W-1:0];
      rqi_pkg::REG_PLANE:  m_pn     = data[rqi_pkg::NVEC_W-1:0];
      rqi_pkg::REG_HORIZ:  m_hn     = data[rqi_pkg::NVEC_W-1:0];
      rqi_pkg::REG_VERT:   m_vn     = data[rqi_pkg::NVEC_W-1:0];
      rqi_pkg::REG_WIDTH:  m_width  = data[rqi_pkg::SIZE_W-1:0];
      rqi_pkg::REG_HEIGHT: m_height = data[rqi_pkg::SIZE_W-1:0];
      rqi_pkg::REG_MIN:    m_min    = data[rqi_pkg::SIZE_W-1:0];
      rqi_pkg::REG_EPS:    m_eps    = data[rqi_pkg::EPS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (rqi_pkg::LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_ray(rqi_pkg::ray_t r, logic typed, isect_t res);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    origin_x_i    <= r.o[0];
    origin_y_i    <= r.o[1];
    origin_z_i    <= r.o[2];
    direction_x_i <= r.dir[0];
    direction_y_i <= r.dir[1];
    direction_z_i <= r.dir[2];
    do @(posedge clk_i); while (busy_o);
    expected_hits.push_back(typed ? res : predict_hit(r));
  endtask

  function automatic logic [rqi_pkg::CFG_DATA_W-1:0] pack_nrm(int a, int b, int c);
    return {16'd0, rqi_pkg::NRM_W'(c), rqi_pkg::NRM_W'(b), rqi_pkg::NRM_W'(a)};
  endfunction

  function automatic logic [rqi_pkg::CFG_DATA_W-1:0] pack_pos(int a, int b, int c);
    return {4'd0, rqi_pkg::COORD_WIDTH'(c), rqi_pkg::COORD_WIDTH'(b),
            rqi_pkg::COORD_WIDTH'(a)};
  endfunction

  // axis-aligned quad with random placement, orientation and size
  task automatic setup_quad(int min_sel, int eps_sel);
    int n[3], h[3], v[3], b, c;
    q_axis = $urandom_range(2);
    b = (q_axis + 1) % 3;
    c = (q_axis + 2) % 3;
    n = '{0, 0, 0}; h = '{0, 0, 0}; v = '{0, 0, 0};
    n[q_axis] = $urandom_range(1) ? 16384 : -16384;
    h[b] = 16384;
    v[c] = 16384;
    for (int i = 0; i < 3; i++) q_corner[i] = $urandom_range(32768) - 16384;
    q_w = $urandom_range(32768);
    q_h = $urandom_range(32768);
    write_reg(rqi_pkg::REG_CORNER, pack_pos(q_corner[0], q_corner[1], q_corner[2]));
    write_reg(rqi_pkg::REG_PLANE, pack_nrm(n[0], n[1], n[2]));
    write_reg(rqi_pkg::REG_HORIZ, pack_nrm(h[0], h[1], h[2]));
    write_reg(rqi_pkg::REG_VERT, pack_nrm(v[0], v[1], v[2]));
    write_reg(rqi_pkg::REG_WIDTH, 64'(q_w));
    write_reg(rqi_pkg::REG_HEIGHT, 64'(q_h));
    case (min_sel)
      0: write_reg(rqi_pkg::REG_MIN, 64'd0);
      1: write_reg(rqi_pkg::REG_MIN, 64'd41);
      2: write_reg(rqi_pkg::REG_MIN, {$urandom, $urandom});
      default: write_reg(rqi_pkg::REG_MIN, 64'(rqi_pkg::DIST_MAX));
    endcase
    case (eps_sel)
      0: write_reg(rqi_pkg::REG_EPS, 64'd0);
      1: write_reg(rqi_pkg::REG_EPS, 64'd1);
      2: write_reg(rqi_pkg::REG_EPS, 64'($urandom_range(8000)));
      default: write_reg(rqi_pkg::REG_EPS, 64'h7fff);
    endcase
  endtask

  function automatic rqi_pkg::ray_t aimed_ray();
    rqi_pkg::ray_t r;
    int b, c, tg[3], ht, sgn;
    b = (q_axis + 1) % 3;
    c = (q_axis + 2) % 3;
    tg[b] = q_corner[b] + $urandom_range(q_w * 3 / 2 + 2) - q_w / 4;
    tg[c] = q_corner[c] + $urandom_range(q_h * 3 / 2 + 2) - q_h / 4;
    tg[q_axis] = q_corner[q_axis];
    ht = $urandom_range(80000) - 40000;
    sgn = (ht > 0) ? -1 : 1;
    if ($urandom_range(7) == 0) sgn = -sgn;
    r.o[q_axis] = rqi_pkg::COORD_WIDTH'(tg[q_axis] + ht);
    r.o[b] = rqi_pkg::COORD_WIDTH'(tg[b]);
    r.o[c] = rqi_pkg::COORD_WIDTH'(tg[c]);
    r.dir[q_axis] = rqi_pkg::NRM_W'(sgn * $urandom_range(16384, 12000));
    r.dir[b] = rqi_pkg::NRM_W'($urandom_range(4000) - 2000);
    r.dir[c] = rqi_pkg::NRM_W'($urandom_range(4000) - 2000);
    return r;
  endfunction

  // results
  always @(posedge clk_i) begin
    isect_t got, exp_r;
    if (rst_ni && done_o) begin
      got = {hit_o, hit_distance_o, point_x_o, point_y_o, point_z_o,
             coord_u_o, coord_v_o, front_entry_o};
      if (expected_hits.size() == 0) begin
        $error("result with no request pending");
        fail_count++;
      end else begin
        exp_r = expected_hits.pop_front();
        if (got.hit != exp_r.hit) begin
          $error("hit exp %0d got %0d", exp_r.hit, got.hit); fail_count++;
        end
        if (got.hit_dist != exp_r.hit_dist) begin
          $error("hit_distance exp %0d got %0d", exp_r.hit_dist, got.hit_dist);
          fail_count++;
        end
        if (got.px != exp_r.px) begin
          $error("point_x exp %0d got %0d", $signed(exp_r.px), $signed(got.px)); fail_count++;
        end
        if (got.py != exp_r.py) begin
          $error("point_y exp %0d got %0d", $signed(exp_r.py), $signed(got.py)); fail_count++;
        end
        if (got.pz != exp_r.pz) begin
          $error("point_z exp %0d got %0d", $signed(exp_r.pz), $signed(got.pz)); fail_count++;
        end
        if (got.u != exp_r.u) begin
          $error("coord_u exp %0d got %0d", $signed(exp_r.u), $signed(got.u)); fail_count++;
        end
        if (got.v != exp_r.v) begin
          $error("coord_v exp %0d got %0d", $signed(exp_r.v), $signed(got.v)); fail_count++;
        end
        if (got.front != exp_r.front) begin
          $error("front_entry exp %0d got %0d", exp_r.front, got.front); fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    progress = (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o);
    if (!rst_ni || progress) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    ray_row_t      rows[$];
    ray_row_t      row;
    rqi_pkg::ray_t r;
    int            phase_idle[7];
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    origin_x_i <= '0; origin_y_i <= '0; origin_z_i <= '0;
    direction_x_i <= '0; direction_y_i <= '0; direction_z_i <= '0;
    fail_count = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    m_corner = '0; m_pn = '0; m_hn = '0; m_vn = '0;
    m_width = '0; m_height = '0; m_min = rqi_pkg::MIN_DIST_RST; m_eps = rqi_pkg::EPS_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset the plane normal is zero: every ray misses
    row.typed = 1'b1;
    row.res = '0;
    row.ray = make_ray(0, 0, 0, 0, 0, 16384);
    rows.push_back(row);
    row.ray = make_ray(524287, 524287, 524287, 32767, 32767, 32767);
    rows.push_back(row);
    row.ray = make_ray(-524288, -524288, -524288, -32768, -32768, -32768);
    rows.push_back(row);
    row.ray = make_ray(-524288, 524287, 1, 32767, -32768, -1);
    rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
    wait_drained();

    // unit square from (-1,-1) to (1,1) in the z = 0 plane, normal +z
    write_reg(rqi_pkg::REG_CORNER, pack_pos(-4096, -4096, 0));
    write_reg(rqi_pkg::REG_PLANE, pack_nrm(0, 0, 16384));
    write_reg(rqi_pkg::REG_HORIZ, pack_nrm(16384, 0, 0));
    write_reg(rqi_pkg::REG_VERT, pack_nrm(0, 16384, 0));
    write_reg(rqi_pkg::REG_WIDTH, 64'd8192);
    write_reg(rqi_pkg::REG_HEIGHT, 64'd8192);
    write_reg(rqi_pkg::REG_MIN, 64'd41);
    write_reg(rqi_pkg::REG_EPS, 64'd1);
    rows.delete();
    row.typed = 1'b0;
    // front hit, back hit, parallel, behind origin, zero distance, outside u/v, edge, corner
    row.ray = make_ray(0, 0, 8192, 0, 0, -16384);
    rows.push_back(row);
    row.ray = make_ray(1000, -1000, -8192, 0, 0, 16384);
    rows.push_back(row);
    row.ray = make_ray(0, 0, 8192, 16384, 0, 0);
    rows.push_back(row);
    row.ray = make_ray(0, 0, 8192, 0, 0, 16384);
    rows.push_back(row);
    row.ray = make_ray(0, 0, 0, 0, 0, -16384);
    rows.push_back(row);
    row.ray = make_ray(9000, 0, 8192, 0, 0, -16384);
    rows.push_back(row);
    row.ray = make_ray(0, -4096, 8192, 0, 0, -16384);
    rows.push_back(row);
    row.ray = make_ray(4096, 4096, 8192, 0, 0, -16384);
    rows.push_back(row);
    // distance saturates
    row.ray = make_ray(0, 0, 524287, 16383, 0, -1);
    rows.push_back(row);
    row.ray = make_ray(0, 0, 4096, 11585, 0, -11585);
    rows.push_back(row);
    foreach (rows[i]) send_ray(rows[i].ray, rows[i].typed, rows[i].res);
    wait_drained();
    write_reg(rqi_pkg::REG_MIN, 64'd0);
    send_ray(rows[4].ray, 1'b0, '0);
    send_ray(rows[0].ray, 1'b0, '0);
    wait_drained();
    write_reg(rqi_pkg::REG_EPS, 64'h7fff);
    send_ray(rows[0].ray, 1'b0, '0);
    send_ray(rows[9].ray, 1'b0, '0);
    wait_drained();

    phase_idle = '{0, 82, 0, 82, 29, 0, 29};
    for (int ph = 0; ph < 7; ph++) begin
      idle_pct = phase_idle[ph];
      if (ph == 5) begin
        // garbage in the geometry registers, minimum distance and epsilon zero
        write_reg(rqi_pkg::REG_CORNER, {$urandom, $urandom});
        write_reg(rqi_pkg::REG_PLANE, {$urandom, $urandom});
        write_reg(rqi_pkg::REG_HORIZ, {$urandom, $urandom});
        write_reg(rqi_pkg::REG_VERT, {$urandom, $urandom});
        write_reg(rqi_pkg::REG_WIDTH, {$urandom, $urandom});
        write_reg(rqi_pkg::REG_HEIGHT, {$urandom, $urandom});
        write_reg(rqi_pkg::REG_MIN, 64'd0);
        write_reg(rqi_pkg::REG_EPS, 64'd0);
      end else begin
        setup_quad(ph == 3 ? 3 : ph % 3, ph == 4 ? 3 : (ph + 1) % 3);
      end
      for (int k = 0; k < 250; k++) begin
        case ($urandom_range(19))
          0, 1, 2: begin
            r.o[0] = rqi_pkg::COORD_WIDTH'($urandom);
            r.o[1] = rqi_pkg::COORD_WIDTH'($urandom);
            r.o[2] = rqi_pkg::COORD_WIDTH'($urandom);
            r.dir[0] = rqi_pkg::NRM_W'($urandom);
            r.dir[1] = rqi_pkg::NRM_W'($urandom);
            r.dir[2] = rqi_pkg::NRM_W'($urandom);
          end
          3, 4: begin
            r = aimed_ray();
            r.dir[$urandom_range(2)] = rqi_pkg::NRM_W'($urandom);
          end
          default: r = aimed_ray();
        endcase
        send_ray(r, 1'b0, '0);
      end
      wait_drained();
    end

    if (expected_hits.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
